// File: hw/rtl/encoder_edge_interval_tachometer_unit_assert.svh
// Assertion macros for the tachometer block.
// Each macro takes a label and a property expression, clocked on clk and
// disabled while rst_n is low.
`ifndef ENCODER_EDGE_INTERVAL_TACHOMETER_UNIT_ASSERT_SVH
`define ENCODER_EDGE_INTERVAL_TACHOMETER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define EEIT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tachometer assertion failed");
`define EEIT_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tachometer forbidden condition seen");
`else
`define EEIT_ASSERT(label, prop)
`define EEIT_ASSERT_NEVER(label, cond)
`endif

`endif

// File: hw/rtl/eeit_pkg.sv
package eeit_pkg;

    // Width of the timestamps and of the stored interval
    localparam int TIME_WIDTH = 64;
    localparam int PORT_TIME_W = 64;
    localparam int SPEED_W = 32;

    localparam logic [SPEED_W-1:0] SPEED_NUM_RESET = 32'd1500000;
    localparam logic [SPEED_W-1:0] SPEED_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = SPEED_W;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int CMP_W = (TIME_WIDTH > SPEED_W + 1) ? TIME_WIDTH : SPEED_W + 1;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic                   command;
        logic                   pin_level;
        logic [PORT_TIME_W-1:0] time_us;
    } in_word_t;

    typedef struct packed {
        logic                   edge_accepted;
        logic                   interval_valid;
        logic [PORT_TIME_W-1:0] interval_us;
        logic [SPEED_W-1:0]     speed;
    } out_word_t;

    typedef struct packed {
        logic                  is_query;
        logic                  edge_accepted;
        logic [TIME_WIDTH-1:0] interval;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// File: hw/rtl/eeit_front.sv
module eeit_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  eeit_pkg::in_word_t in_word,
    output eeit_pkg::q_entry_t entry
);
    import eeit_pkg::*;

    logic                  last_level_reg, last_level_next;
    logic [TIME_WIDTH-1:0] rise_reg, rise_next;
    logic [TIME_WIDTH-1:0] fall_reg, fall_next;
    logic [TIME_WIDTH-1:0] interval_reg, interval_next;
    logic [TIME_WIDTH-1:0] now;
    logic                  level_changed;

    assign now = in_word.time_us[TIME_WIDTH-1:0];
    assign level_changed = (in_word.command == CMD_EDGE)
                           && (in_word.pin_level != last_level_reg);

    always_comb
    begin
        last_level_next = last_level_reg;
        rise_next = rise_reg;
        fall_next = fall_reg;
        interval_next = interval_reg;
        if (level_changed)
        begin
            last_level_next = in_word.pin_level;
            if (in_word.pin_level)
            begin
                rise_next = now;
                if (fall_reg != '0)
                begin
                    interval_next = now - fall_reg;
                end
            end
            else
            begin
                fall_next = now;
                if (rise_reg != '0)
                begin
                    interval_next = now - rise_reg;
                end
            end
        end
    end

    // Entry carries the interval as it stands after this word
    always_comb
    begin
        entry.is_query = (in_word.command == CMD_QUERY);
        entry.edge_accepted = level_changed;
        entry.interval = interval_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            rise_reg <= '0;
            fall_reg <= '0;
            interval_reg <= '0;
        end
        else if (accept)
        begin
            last_level_reg <= last_level_next;
            rise_reg <= rise_next;
            fall_reg <= fall_next;
            interval_reg <= interval_next;
        end
    end

endmodule

// File: hw/rtl/eeit_queue.sv
module eeit_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  eeit_pkg::q_entry_t  wr_entry,
    input  logic                rd_en,
    output eeit_pkg::q_entry_t  rd_entry,
    output eeit_pkg::q_status_t status
);
    import eeit_pkg::*;

    q_entry_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_wr, do_rd;

    assign status.empty = (count_reg == '0);
    assign status.full = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/eeit_back.sv
module eeit_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [eeit_pkg::SPEED_W-1:0]  cfg_wr_data,
    input  eeit_pkg::q_entry_t            q_entry,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output eeit_pkg::out_word_t           out_word
);
    import eeit_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                  state_reg, state_next;
    logic [SPEED_W-1:0]    num_reg;
    logic [SPEED_W-1:0]    quo_reg, quo_next;
    logic [SPEED_W-1:0]    rem_reg, rem_next;
    logic [TIME_WIDTH-1:0] divisor_reg, divisor_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_reg, out_next;
    logic                  take;
    logic [SPEED_W:0]      trial;
    logic [CMP_W-1:0]      trial_ext, div_ext, diff;
    logic                  fits;

    assign empty = !out_valid_reg;
    assign out_word = out_reg;
    assign take = (state_reg == ST_IDLE) && !q_empty && (!out_valid_reg || pop);
    assign q_pop = take;

    // Restoring step: shift in the next numerator bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[SPEED_W-1]};
    assign trial_ext = CMP_W'(trial);
    assign div_ext = CMP_W'(divisor_reg);
    assign fits = (trial_ext >= div_ext);
    assign diff = trial_ext - div_ext;

    always_comb
    begin
        state_next = state_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        divisor_next = divisor_reg;
        cnt_next = cnt_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !pop;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (q_entry.is_query && (q_entry.interval != '0))
                    begin
                        quo_next = num_reg;
                        rem_next = '0;
                        divisor_next = q_entry.interval;
                        cnt_next = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        out_next.edge_accepted = q_entry.edge_accepted;
                        out_next.interval_valid = (q_entry.interval != '0);
                        out_next.interval_us = PORT_TIME_W'(q_entry.interval);
                        out_next.speed = q_entry.is_query ? SPEED_ALL_ONES : '0;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
                quo_next = {quo_reg[SPEED_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    out_next.edge_accepted = 1'b0;
                    out_next.interval_valid = 1'b1;
                    out_next.interval_us = PORT_TIME_W'(divisor_reg);
                    out_next.speed = {quo_reg[SPEED_W-2:0], fits};
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        divisor_reg <= divisor_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            num_reg <= SPEED_NUM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                num_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// File: hw/rtl/encoder_edge_interval_tachometer_unit.sv
// Encoder edge-interval tachometer. Push words of two kinds: an edge event
// (command 0) carrying the sampled pin level and a microsecond timestamp, or
// a speed query (command 1). Every word gives exactly one result word, in
// order. An edge whose level differs from the last accepted level stores its
// timestamp; when the opposite edge has a nonzero timestamp the half-period
// interval (difference modulo the timestamp width) is stored. A query returns
// cfg_wr_data's last written value (reset 1500000) divided by that interval,
// truncated, or all ones while the interval is zero. The front stage updates
// the edge state in the cycle a word is taken and places it in a four-word
// queue; the back stage turns each queued word into a result. An edge event
// or a query on a zero interval is registered into the result word when the
// back stage takes it from the queue; a query on a nonzero interval occupies
// the serial restoring divider, one quotient bit per cycle, and the divider
// sets the sustained rate for queries. Edge words keep being accepted while a
// division runs until the queue fills. Write the numerator only while no words
// are in flight.
`include "encoder_edge_interval_tachometer_unit_assert.svh"

module encoder_edge_interval_tachometer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  eeit_pkg::in_word_t            in_word,
    output logic                          empty,
    input  logic                          pop,
    output eeit_pkg::out_word_t           out_word,
    input  logic                          cfg_wr_en,
    input  logic [eeit_pkg::SPEED_W-1:0]  cfg_wr_data
);
    import eeit_pkg::*;

    logic      accept;
    q_entry_t  front_entry;
    q_entry_t  head_entry;
    q_status_t q_status;
    logic      q_pop;

    // Take a word only while the queue has room
    assign full = q_status.full;
    assign accept = push && !q_status.full;

    // Front: classify the word and advance the edge state
    eeit_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_word (in_word),
        .entry   (front_entry)
    );

    // Queue: hold classified words until the back is free
    eeit_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_entry (front_entry),
        .rd_en    (q_pop),
        .rd_entry (head_entry),
        .status   (q_status)
    );

    // Back: run the division for queries and hold the result word
    eeit_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_entry     (head_entry),
        .q_empty     (q_status.empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_word    (out_word)
    );

    // An edge result never carries a speed
    `EEIT_ASSERT(a_edge_no_speed, (!empty && out_word.edge_accepted) |-> (out_word.speed == '0))
    // The valid flag tracks a nonzero interval
    `EEIT_ASSERT(a_valid_matches, !empty |-> (out_word.interval_valid == (out_word.interval_us != '0)))
    // The back never drains an empty queue
    `EEIT_ASSERT_NEVER(a_pop_empty_queue, q_pop && q_status.empty)
    // Queue cannot be both empty and full
    `EEIT_ASSERT_NEVER(a_queue_status, q_status.empty && q_status.full)

endmodule
